FILE: rtl/csic_pkg.sv
// Shared types, constants and character decode for the character-stream calculator.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package csic_pkg;

    localparam int WIDTH  = 64;               // arithmetic word width (16..64)
    localparam int OUT_W  = 64;               // result field width
    localparam int CHAR_W = 8;
    localparam int CNT_W  = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_MOD  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_RUN,
        ST_FINISH,
        ST_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic digit_load;
        logic op_start;
        logic op_step;
        logic commit;
        logic emit;
        t_op  new_op;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic iterative;
        logic out_free;
    } t_dp_stat;

    function automatic t_op decode_op(input logic [CHAR_W-1:0] c);
        t_op op;
        case (c)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            CH_PCT:   op = OP_MOD;
            default:  op = OP_NONE;
        endcase
        return op;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/csic_in_if.sv
// Input channel: one character beat per valid/ready handshake.
// Depends on csic_pkg for the character width.
`default_nettype none

interface csic_in_if import csic_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              line_end;

    modport source (output valid, char_code, line_end, input ready);
    modport sink   (input valid, char_code, line_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/csic_res_if.sv
// Result channel: one line result beat per valid/ready handshake.
// Depends on csic_pkg for the result width.
`default_nettype none

interface csic_res_if import csic_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] value;
    logic                    div_zero;

    modport source (output valid, value, div_zero, input ready);
    modport sink   (input valid, value, div_zero, output ready);
endinterface

`default_nettype wire

FILE: rtl/csic_ctrl.sv
// Sequencer for the calculator: decodes each character beat and steps the datapath
// through operand load, bit-serial multiply/divide, commit and result emit. Uses csic_pkg.
`default_nettype none

module csic_ctrl import csic_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic              i_line_end,
    output      logic              o_in_ready,
    input  wire t_dp_stat          i_stat,
    output      t_dp_cmd           o_cmd
);

    t_state           r_state, n_state;
    t_op              r_new_op, n_new_op;
    logic             r_last, n_last;
    logic             r_final, n_final;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic accept;
    t_op  in_op;

    assign in_op  = decode_op(i_char_code);
    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_new_op <= OP_NONE;
            r_last   <= 1'b0;
            r_final  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_new_op <= n_new_op;
            r_last   <= n_last;
            r_final  <= n_final;
            r_cnt    <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_new_op = r_new_op;
        n_last   = r_last;
        n_final  = r_final;
        n_cnt    = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_new_op = in_op;
                    n_last   = i_line_end;
                    if (in_op != OP_NONE) begin
                        n_state = ST_START;
                        n_final = 1'b0;
                    end else if (i_line_end) begin
                        n_state = ST_START;
                        n_final = 1'b1;
                    end
                end
            end
            ST_START: begin
                n_cnt = '0;
                if (i_stat.iterative) begin
                    n_state = ST_RUN;
                end else if (r_final) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = r_final ? ST_EMIT : ST_FINISH;
                end
            end
            ST_FINISH: begin
                // an operator on the last character still needs the closing apply
                if (r_last) begin
                    n_state = ST_START;
                    n_final = 1'b1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.new_op = r_new_op;
        case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.digit_load = i_in_valid && is_digit(i_char_code);
            end
            ST_START:  o_cmd.op_start = 1'b1;
            ST_RUN:    o_cmd.op_step  = 1'b1;
            ST_FINISH: o_cmd.commit   = 1'b1;
            ST_EMIT:   o_cmd.emit     = i_stat.out_free;
            default: ;
        endcase
    end

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result emitted while output register still full");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.digit_load, o_cmd.op_start, o_cmd.op_step, o_cmd.commit, o_cmd.emit}))
        else $error("more than one datapath command in a cycle");

    a_op_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_op != OP_NONE) |=> (r_state == ST_START && !r_final))
        else $error("operator beat did not start an apply");

endmodule

`default_nettype wire

FILE: rtl/csic_dp.sv
// Datapath: line state registers, shared shift-add multiplier / restoring divider,
// result select and output register. Driven by csic_ctrl; uses csic_pkg.
`default_nettype none

module csic_dp import csic_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    input  wire logic [CHAR_W-1:0]       i_char_code,
    output      t_dp_stat                o_stat,
    input  wire logic                    i_out_ready,
    output      logic                    o_out_valid,
    output      logic signed [OUT_W-1:0] o_value,
    output      logic                    o_div_zero
);

    logic [WIDTH-1:0] r_running, r_operand;
    t_op              r_pending;
    logic             r_err;

    // shared iteration registers: x = accumulator / remainder, y = multiplier / quotient,
    // z = multiplicand / divisor
    logic [WIDTH-1:0] r_x, r_y, r_z;
    logic             r_na, r_nb, r_dz;

    logic signed [OUT_W-1:0] r_value;
    logic                    r_div_zero, r_out_valid;

    logic             a_neg, b_neg;
    logic [WIDTH-1:0] a_mag, b_mag;
    logic [WIDTH:0]   div_shift, div_diff;
    logic             div_ge;
    logic [WIDTH-1:0] mul_sum;
    logic [WIDTH-1:0] result;
    logic             is_divmod, dz_now;

    assign a_neg = r_running[WIDTH-1];
    assign b_neg = r_operand[WIDTH-1];
    assign a_mag = a_neg ? ('0 - r_running) : r_running;
    assign b_mag = b_neg ? ('0 - r_operand) : r_operand;

    assign div_shift = {r_x, r_y[WIDTH-1]};
    assign div_diff  = div_shift - {1'b0, r_z};
    assign div_ge    = !div_diff[WIDTH];
    assign mul_sum   = r_x + (r_y[0] ? r_z : '0);

    assign is_divmod = (r_pending == OP_DIV) || (r_pending == OP_MOD);
    assign dz_now    = is_divmod && r_dz;

    always_comb begin
        case (r_pending)
            OP_ADD:  result = r_running + r_operand;
            OP_SUB:  result = r_running - r_operand;
            OP_MUL:  result = r_x;
            OP_DIV:  result = r_dz ? '0 : ((r_na ^ r_nb) ? ('0 - r_y) : r_y);
            OP_MOD:  result = r_dz ? '0 : (r_na ? ('0 - r_x) : r_x);
            default: result = r_operand;
        endcase
    end

    assign o_stat.iterative = (r_pending == OP_MUL) || is_divmod;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_operand <= '0;
            r_pending <= OP_NONE;
            r_err     <= 1'b0;
        end else begin
            if (i_cmd.digit_load) begin
                r_operand <= (r_operand << 3) + (r_operand << 1) + WIDTH'(i_char_code[3:0]);
            end
            if (i_cmd.commit) begin
                r_running <= result;
                r_operand <= '0;
                r_pending <= i_cmd.new_op;
                r_err     <= r_err | dz_now;
            end
            if (i_cmd.emit) begin
                r_running <= '0;
                r_operand <= '0;
                r_pending <= OP_NONE;
                r_err     <= 1'b0;
            end
        end
    end

    // multiply / divide unit, one bit per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.op_start) begin
            r_x  <= '0;
            r_na <= a_neg;
            r_nb <= b_neg;
            r_dz <= (r_operand == '0);
            if (r_pending == OP_MUL) begin
                r_y <= r_operand;
                r_z <= r_running;
            end else begin
                r_y <= a_mag;
                r_z <= b_mag;
            end
        end else if (i_cmd.op_step) begin
            if (r_pending == OP_MUL) begin
                r_x <= mul_sum;
                r_y <= r_y >> 1;
                r_z <= r_z << 1;
            end else begin
                r_x <= div_ge ? div_diff[WIDTH-1:0] : div_shift[WIDTH-1:0];
                r_y <= {r_y[WIDTH-2:0], div_ge};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_value    <= OUT_W'(signed'(result));
            r_div_zero <= r_err | dz_now;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_div_zero  = r_div_zero;

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_running == '0 && r_operand == '0 && r_pending == OP_NONE
                        && !r_err && r_out_valid))
        else $error("line state not cleared after result");

    a_commit_clears_operand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_operand == '0))
        else $error("operand not cleared after operator");

    a_dz_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && dz_now) |=> r_div_zero)
        else $error("closing divide by zero not flagged");

endmodule

`default_nettype wire

FILE: rtl/char_stream_integer_calculator.sv
// Top level of the character-stream integer calculator: joins csic_ctrl and csic_dp
// to the csic_in_if input and csic_res_if result channels. Uses csic_pkg.
//
// One ASCII character per input beat; expressions evaluate strictly left to right.
// A digit or an ignored character is taken without leaving the idle state. An operator
// steps through start and finish when the pending operation is none, + or -, and through
// start, run and finish when it is * / or %, since the shared shift-add multiplier /
// restoring divider resolves one bit per cycle. A line-end beat runs the closing operation
// the same way and then loads the output register, so an operator on the last character
// runs its own apply and then the closing apply. The output register holds one result, so
// the next line can start while the previous result waits; a second result waits for it.
`default_nettype none

module char_stream_integer_calculator import csic_pkg::*; (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    csic_in_if.sink   i_in,
    csic_res_if.source o_res
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    csic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_char_code (i_in.char_code),
        .i_line_end  (i_in.line_end),
        .o_in_ready  (i_in.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    csic_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_char_code (i_in.char_code),
        .o_stat      (stat),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_value     (o_res.value),
        .o_div_zero  (o_res.div_zero)
    );

endmodule

`default_nettype wire

FILE: tb/sv/char_stream_integer_calculator_tb.sv
// Self-checking testbench for char_stream_integer_calculator: feeds expression lines one
// character per beat and checks every line result against a local left-to-right evaluator.
// Depends on csic_pkg, csic_in_if and csic_res_if from rtl/.
module char_stream_integer_calculator_tb import csic_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1350;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int TAIL_CYCLES = 200;
    localparam logic [WIDTH-1:0] TEN = WIDTH'(10);

    typedef struct {
        logic [OUT_W-1:0] value;
        logic             div_zero;
    } t_line_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    csic_in_if  in_if();
    csic_res_if res_if();

    char_stream_integer_calculator dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_res  (res_if)
    );

    always #10 i_clk = ~i_clk;

    // evaluator state
    logic [WIDTH-1:0] calc_running = '0;
    logic [WIDTH-1:0] calc_operand = '0;
    t_op              calc_pending = OP_NONE;
    logic             calc_div_err = 1'b0;

    t_line_result line_results[$];
    t_line_result expected_line;
    logic [7:0]   line_buf[$];
    logic [7:0]   op_chars[5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT};

    int mismatches = 0;
    int items_sent = 0;
    int burst_left = 0;
    int cycle_count = 0;
    int rx_hold_cycles = 0;
    int rx_mode = 0;
    int rx_left = 0;

    function automatic logic [WIDTH-1:0] fold_op(input t_op op, input logic [WIDTH-1:0] lhs,
                                                 input logic [WIDTH-1:0] rhs,
                                                 output logic by_zero);
        logic [WIDTH-1:0] mag_l;
        logic [WIDTH-1:0] mag_r;
        logic [WIDTH-1:0] q;
        logic [WIDTH-1:0] r;
        logic             neg_l;
        logic             neg_r;
        by_zero = 1'b0;
        neg_l = lhs[WIDTH-1];
        neg_r = rhs[WIDTH-1];
        mag_l = neg_l ? -lhs : lhs;
        mag_r = neg_r ? -rhs : rhs;
        case (op)
            OP_ADD: r = lhs + rhs;
            OP_SUB: r = lhs - rhs;
            OP_MUL: r = lhs * rhs;
            OP_DIV, OP_MOD: begin
                if (rhs == '0) begin
                    by_zero = 1'b1;
                    r = '0;
                end else if (op == OP_DIV) begin
                    q = mag_l / mag_r;
                    r = (neg_l != neg_r) ? -q : q;
                end else begin
                    // remainder takes the sign of the dividend
                    q = mag_l % mag_r;
                    r = neg_l ? -q : q;
                end
            end
            default: r = rhs;
        endcase
        return r;
    endfunction

    task automatic evaluate_char(input logic [7:0] c, input logic last);
        t_op                     op;
        logic                    by_zero;
        logic [WIDTH-1:0]        digit;
        logic [WIDTH-1:0]        final_word;
        logic signed [WIDTH-1:0] final_signed;
        logic signed [OUT_W-1:0] final_wide;
        t_line_result            res;
        case (c)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            CH_PCT:   op = OP_MOD;
            default:  op = OP_NONE;
        endcase
        digit = '0;
        digit[3:0] = c[3:0];
        if (c >= CH_ZERO && c <= CH_NINE) begin
            calc_operand = calc_operand * TEN + digit;
        end else if (op != OP_NONE) begin
            calc_running = fold_op(calc_pending, calc_running, calc_operand, by_zero);
            calc_div_err = calc_div_err | by_zero;
            calc_operand = '0;
            calc_pending = op;
        end
        if (last) begin
            final_word = fold_op(calc_pending, calc_running, calc_operand, by_zero);
            final_signed = final_word;
            final_wide = final_signed;
            res.value = final_wide;
            res.div_zero = calc_div_err | by_zero;
            line_results.push_back(res);
            calc_running = '0;
            calc_operand = '0;
            calc_pending = OP_NONE;
            calc_div_err = 1'b0;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.char_code = c;
        in_if.line_end = last;
        do @(posedge i_clk); while (!in_if.ready);
        evaluate_char(c, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_buf.push_back(s[i]);
        end
    endtask

    task automatic push_digits(input int count);
        logic [7:0] ch;
        for (int i = 0; i < count; i++) begin
            ch = CH_ZERO + 8'($urandom_range(0, 9));
            line_buf.push_back(ch);
        end
    endtask

    task automatic push_spaces();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(" ");
        end
    endtask

    task automatic push_operand();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            // leave the operand out
        end else if (kind < 16) begin
            line_buf.push_back(CH_ZERO);
        end else if (kind < 20) begin
            push_text("9223372036854775808");
        end else if (kind < 24) begin
            push_text("18446744073709551615");
        end else if (kind < 28) begin
            push_digits($urandom_range(19, 24));
        end else begin
            push_digits($urandom_range(1, 3));
        end
    endtask

    task automatic build_random_line();
        int terms;
        line_buf.delete();
        if ($urandom_range(0, 4) == 0) line_buf.push_back(op_chars[$urandom_range(0, 4)]);
        terms = $urandom_range(1, 5);
        for (int t = 0; t < terms; t++) begin
            push_spaces();
            push_operand();
            if ($urandom_range(0, 7) == 0) line_buf.push_back(8'($urandom_range(0, 255)));
            push_spaces();
            if (t != terms - 1) line_buf.push_back(op_chars[$urandom_range(0, 4)]);
        end
        if ($urandom_range(0, 9) == 0) line_buf.push_back(op_chars[$urandom_range(0, 4)]);
        if (line_buf.size() == 0) line_buf.push_back(" ");
    endtask

    task automatic send_line_buf();
        for (int i = 0; i < line_buf.size(); i++) begin
            send_char(line_buf[i], i == line_buf.size() - 1);
        end
    endtask

    task automatic test_basic_ops();
        send_text("42");
        send_text("7+3");
        send_text("2-9*4");
        send_text("-7/2");
        send_text("9%4");
    endtask

    task automatic test_special_lines();
        send_text("9%0");
        send_text("8/");
        // non-printing codes only: an empty line
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_extreme_operands();
        send_text("9223372036854775808/18446744073709551615");
        send_text("9223372036854775808%18446744073709551615");
        send_text("99999999999999999999999*3");
        send_text("0-9223372036854775808-1");
    endtask

    task automatic test_result_stall();
        // hold the result side long enough for the block to back up into its input
        rx_hold_cycles = 600;
        send_text("12*34");
        send_text("100/7");
        send_text("5%3");
        send_text("6*6*6");
    endtask

    task automatic test_random_lines();
        while (items_sent < ITEM_TARGET) begin
            build_random_line();
            send_line_buf();
        end
    endtask

    // result side: stall on a changing pattern, or hold off on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                res_if.ready = 1'b0;
                repeat (rx_hold_cycles) @(negedge i_clk);
                rx_hold_cycles = 0;
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                0:       res_if.ready = 1'b1;
                1:       res_if.ready = 1'($urandom_range(0, 1));
                default: res_if.ready = ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (line_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, got value %0d div_zero %0b",
                         $time, res_if.value, res_if.div_zero);
                mismatches++;
            end else begin
                expected_line = line_results.pop_front();
                if (res_if.value !== expected_line.value) begin
                    $display("%0t: value mismatch: expected %0d, got %0d",
                             $time, $signed(expected_line.value), res_if.value);
                    mismatches++;
                end
                if (res_if.div_zero !== expected_line.div_zero) begin
                    $display("%0t: div_zero mismatch: expected %0b, got %0b",
                             $time, expected_line.div_zero, res_if.div_zero);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, line_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        in_if.valid = 1'b0;
        in_if.char_code = '0;
        in_if.line_end = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_basic_ops();
        test_special_lines();
        test_extreme_operands();
        test_result_stall();
        test_random_lines();

        in_if.valid = 1'b0;
        while (line_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
